[rtl/core/force_torque_bias_and_calibration_assert.svh]
// Assertion macros shared by the force/torque calibration RTL.
`ifndef FORCE_TORQUE_BIAS_AND_CALIBRATION_ASSERT_SVH
`define FORCE_TORQUE_BIAS_AND_CALIBRATION_ASSERT_SVH
`ifndef SYNTH
// Antecedent implies consequent in the same cycle.
`define FTBC_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Antecedent implies consequent in the next cycle.
`define FTBC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
// Condition must never hold.
`define FTBC_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);
`else
`define FTBC_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define FTBC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`define FTBC_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

[rtl/core/ftbc_pkg.sv]
// Types, constants and the calibration coefficient table for the force/torque block.
package ftbc_pkg;

   localparam int CHANNELS     = 6;
   localparam int SAMPLE_WIDTH = 16;
   localparam int BIAS_SAMPLES = 64;
   localparam int BIAS_SHIFT   = $clog2(BIAS_SAMPLES + 1) - 1;
   localparam int SUM_WIDTH    = SAMPLE_WIDTH + BIAS_SHIFT;
   localparam int DIFF_WIDTH   = SAMPLE_WIDTH + 2;
   localparam int COEF_WIDTH   = 32;
   localparam int COEF_FRAC    = 22;
   localparam int PROD_WIDTH   = COEF_WIDTH + DIFF_WIDTH;
   localparam int ACC_WIDTH    = PROD_WIDTH + 3;
   localparam int RESULT_WIDTH = 32;
   localparam int COL_WIDTH    = $clog2(CHANNELS);
   localparam int ACTION_WIDTH = 2;

   localparam logic [COL_WIDTH-1:0] FIRST_COL = '0;
   localparam logic [COL_WIDTH-1:0] LAST_COL  = COL_WIDTH'(CHANNELS - 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [ACTION_WIDTH-1:0] ACTION_CLEAR   = 2'd0;
   localparam logic [ACTION_WIDTH-1:0] ACTION_ACCUM   = 2'd1;
   localparam logic [ACTION_WIDTH-1:0] ACTION_CONVERT = 2'd2;

   // 20 * 2^22 * 1e4: channel LSB to Q16.16, Q10.22 coefficient, matrix held in 1e-5 units
   localparam longint COEF_NUM        = 64'sd838860800000;
   // axis scales in 1e-9 units
   localparam longint SCALE_FORCE_XY  = 64'sd4551197212;
   localparam longint SCALE_FORCE_Z   = 64'sd1412440514;
   localparam longint SCALE_TORQUE_XY = 64'sd84884324558;
   localparam longint SCALE_TORQUE_Z  = 64'sd80947203753;

   typedef struct packed {
      logic [ACTION_WIDTH-1:0]        action;
      logic signed [SAMPLE_WIDTH-1:0] channel_0;
      logic signed [SAMPLE_WIDTH-1:0] channel_1;
      logic signed [SAMPLE_WIDTH-1:0] channel_2;
      logic signed [SAMPLE_WIDTH-1:0] channel_3;
      logic signed [SAMPLE_WIDTH-1:0] channel_4;
      logic signed [SAMPLE_WIDTH-1:0] channel_5;
   } req_type;

   typedef struct packed {
      logic signed [RESULT_WIDTH-1:0] force_x;
      logic signed [RESULT_WIDTH-1:0] force_y;
      logic signed [RESULT_WIDTH-1:0] force_z;
      logic signed [RESULT_WIDTH-1:0] torque_x;
      logic signed [RESULT_WIDTH-1:0] torque_y;
      logic signed [RESULT_WIDTH-1:0] torque_z;
   } rsp_type;

   // one channel column issued to the bias store
   typedef struct packed {
      logic                    valid;
      logic [ACTION_WIDTH-1:0] action;
      logic [COL_WIDTH-1:0]    col;
   } issue_type;

   // one bias-corrected column headed for the multipliers
   typedef struct packed {
      logic                 valid;
      logic [COL_WIDTH-1:0] col;
   } diff_ctl_type;

   // round(20 * 2^22 * M / S) with M in 1e-5 units and S chosen by output axis
   function automatic logic signed [COEF_WIDTH-1:0] coef_entry(input int row,
                                                               input longint m_e5);
      longint mag;
      longint q;
      mag = (m_e5 < 0) ? -m_e5 : m_e5;
      case (row) inside
         0, 1:    q = (mag * COEF_NUM + SCALE_FORCE_XY / 2) / SCALE_FORCE_XY;
         2:       q = (mag * COEF_NUM + SCALE_FORCE_Z / 2) / SCALE_FORCE_Z;
         3, 4:    q = (mag * COEF_NUM + SCALE_TORQUE_XY / 2) / SCALE_TORQUE_XY;
         default: q = (mag * COEF_NUM + SCALE_TORQUE_Z / 2) / SCALE_TORQUE_Z;
      endcase
      if (m_e5 < 0) begin
         q = -q;
      end
      return COEF_WIDTH'(q);
   endfunction

   // row per output axis (fx, fy, fz, tx, ty, tz), column per gauge channel
   localparam logic signed [COEF_WIDTH-1:0] COEF_TABLE [CHANNELS][CHANNELS] = '{
      '{coef_entry(0, -40709),   coef_entry(0, -27318),  coef_entry(0, 34868),
        coef_entry(0, -3358156), coef_entry(0, -32609),  coef_entry(0, 3354162)},
      '{coef_entry(1, 35472),    coef_entry(1, 3822730), coef_entry(1, -41173),
        coef_entry(1, -1949156), coef_entry(1, 49550),   coef_entry(1, -1915271)},
      '{coef_entry(2, 1872635),  coef_entry(2, -59676),  coef_entry(2, 1927843),
        coef_entry(2, -56931),   coef_entry(2, 1869352), coef_entry(2, -67633)},
      '{coef_entry(3, -40836),   coef_entry(3, -95908),  coef_entry(3, -3337957),
        coef_entry(3, 138537),   coef_entry(3, 3252522), coef_entry(3, -51156)},
      '{coef_entry(4, 3713715),  coef_entry(4, -102875), coef_entry(4, -2000474),
        coef_entry(4, -27959),   coef_entry(4, -1934135), coef_entry(4, 142577)},
      '{coef_entry(5, -15775),   coef_entry(5, -1816831), coef_entry(5, -133),
        coef_entry(5, -1878961), coef_entry(5, 31895),   coef_entry(5, -1838586)}
   };

endpackage

[rtl/core/force_torque_bias_and_calibration.sv]
// Top level: six-axis force/torque converter with bias removal and a fixed calibration matrix.
// A convert item is walked column by column through the bias store and multiply-accumulate lanes.
// Items are taken back to back while a queue slot is free; the column sequencer steps one gauge channel
// per cycle through the bias memory port and the six multiply-accumulate lanes.
// Reset: bias sums read as zero through per-entry valid bits, result queue empty.
module force_torque_bias_and_calibration (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ftbc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ftbc_pkg::rsp_type rsp_data
);
   import ftbc_pkg::*;

   // item being walked column by column
   req_type                        item_ff;
   logic                           busy_ff;
   logic [COL_WIDTH-1:0]           col_ff;
   logic                           req_accept;
   logic                           can_reserve;
   logic signed [SAMPLE_WIDTH-1:0] col_sample;
   issue_type                      issue;
   diff_ctl_type                   diff_ctl;
   logic signed [DIFF_WIDTH-1:0]   diff;
   logic                           fin_valid;
   rsp_type                        fin_data;

   // take a new item when idle or in the last column of the current one, provided a queue slot is free
   assign req_ready  = (!busy_ff || col_ff == LAST_COL) && can_reserve;
   assign req_accept = req_valid && req_ready;

   // pick the channel for the column being issued
   always_comb begin
      case (col_ff)
         3'd0:    col_sample = item_ff.channel_0;
         3'd1:    col_sample = item_ff.channel_1;
         3'd2:    col_sample = item_ff.channel_2;
         3'd3:    col_sample = item_ff.channel_3;
         3'd4:    col_sample = item_ff.channel_4;
         3'd5:    col_sample = item_ff.channel_5;
         default: col_sample = '0;
      endcase
   end

   assign issue.valid  = busy_ff;
   assign issue.action = item_ff.action;
   assign issue.col    = col_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= req_data;
      end
   end

   // column sequencer: hold the item through all six columns, advance one column a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         col_ff  <= FIRST_COL;
      end else if (req_accept) begin
         busy_ff <= 1'b1;
         col_ff  <= FIRST_COL;
      end else if (busy_ff) begin
         if (col_ff == LAST_COL) begin
            busy_ff <= 1'b0;
            col_ff  <= FIRST_COL;
         end else begin
            col_ff <= col_ff + COL_WIDTH'(1);
         end
      end
   end

   ftbc_bias_store u_bias_store (
      .clock    (clock),
      .reset    (reset),
      .issue    (issue),
      .sample   (col_sample),
      .diff_ctl (diff_ctl),
      .diff     (diff)
   );

   ftbc_mac_array u_mac_array (
      .clock     (clock),
      .reset     (reset),
      .diff_ctl  (diff_ctl),
      .diff      (diff),
      .fin_valid (fin_valid),
      .fin_data  (fin_data)
   );

   // reserve a slot per convert item at acceptance; clear, accumulate and unused codes take none
   ftbc_rsp_queue u_rsp_queue (
      .clock       (clock),
      .reset       (reset),
      .reserve     (req_accept && req_data.action == ACTION_CONVERT),
      .can_reserve (can_reserve),
      .push        (fin_valid),
      .push_data   (fin_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   `FTBC_ASSERT_NEXT(a_col_advance, clock, reset, busy_ff && (col_ff != LAST_COL), busy_ff && (col_ff == $past(col_ff) + COL_WIDTH'(1)), "column sequencer skipped or stalled")

endmodule

[rtl/core/ftbc_bias_store.sv]
// Bias sum memory with read-modify-write and bias subtraction, one channel per cycle.
`include "force_torque_bias_and_calibration_assert.svh"
module ftbc_bias_store (
   input  logic                                      clock,
   input  logic                                      reset,
   input  ftbc_pkg::issue_type                       issue,
   input  logic signed [ftbc_pkg::SAMPLE_WIDTH-1:0]  sample,
   output ftbc_pkg::diff_ctl_type                    diff_ctl,
   output logic signed [ftbc_pkg::DIFF_WIDTH-1:0]    diff
);
   import ftbc_pkg::*;

   localparam logic signed [SUM_WIDTH:0] BIAS_HALF =
      ((SUM_WIDTH + 1)'(1) << BIAS_SHIFT) >> 1;
   localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH - 1){1'b1}}};
   localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH - 1){1'b0}}};

   logic signed [SUM_WIDTH-1:0]    bias_mem [CHANNELS];
   logic [CHANNELS-1:0]            entry_valid_ff;
   logic signed [SUM_WIDTH-1:0]    rd_data_ff;
   logic                           rd_valid_ff;
   issue_type                      b_issue_ff;
   logic signed [SAMPLE_WIDTH-1:0] b_sample_ff;
   diff_ctl_type                   diff_ctl_ff;
   diff_ctl_type                   diff_ctl_in;
   logic signed [DIFF_WIDTH-1:0]   diff_ff;
   logic signed [DIFF_WIDTH-1:0]   diff_in;

   logic signed [SUM_WIDTH-1:0]    rd_sum;
   logic signed [SUM_WIDTH:0]      acc_sum;
   logic signed [SUM_WIDTH-1:0]    sat_sum;
   logic signed [SUM_WIDTH:0]      rnd_sum;
   logic signed [SAMPLE_WIDTH:0]   bias_val;
   logic                           wr_en;
   logic signed [SUM_WIDTH-1:0]    wr_data;

   always_comb begin
      rd_sum  = rd_valid_ff ? rd_data_ff : '0;
      acc_sum = (SUM_WIDTH + 1)'(rd_sum) + (SUM_WIDTH + 1)'(b_sample_ff);
      if (acc_sum[SUM_WIDTH] != acc_sum[SUM_WIDTH-1]) begin
         sat_sum = acc_sum[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
      end else begin
         sat_sum = acc_sum[SUM_WIDTH-1:0];
      end
      rnd_sum  = (SUM_WIDTH + 1)'(rd_sum) + BIAS_HALF;
      bias_val = rnd_sum[SUM_WIDTH:BIAS_SHIFT];
      diff_in  = DIFF_WIDTH'(b_sample_ff) - DIFF_WIDTH'(bias_val);

      wr_en   = b_issue_ff.valid &&
                (b_issue_ff.action == ACTION_CLEAR || b_issue_ff.action == ACTION_ACCUM);
      wr_data = (b_issue_ff.action == ACTION_ACCUM) ? sat_sum : '0;

      diff_ctl_in.valid = b_issue_ff.valid && (b_issue_ff.action == ACTION_CONVERT);
      diff_ctl_in.col   = b_issue_ff.col;
   end

   // memory: write back in the modify stage, registered read in the issue stage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bias_mem[b_issue_ff.col] <= wr_data;
      end
      if (issue.valid) begin
         rd_data_ff <= bias_mem[issue.col];
      end
      b_sample_ff <= sample;
      diff_ff     <= diff_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         rd_valid_ff    <= 1'b0;
         b_issue_ff     <= '0;
         diff_ctl_ff    <= '0;
      end else begin
         if (wr_en) begin
            entry_valid_ff[b_issue_ff.col] <= 1'b1;
         end
         rd_valid_ff <= issue.valid && entry_valid_ff[issue.col];
         b_issue_ff  <= issue;
         diff_ctl_ff <= diff_ctl_in;
      end
   end

   assign diff_ctl = diff_ctl_ff;
   assign diff     = diff_ff;

   `FTBC_ASSERT_NEVER(a_rmw_overlap, clock, reset, wr_en && issue.valid && (b_issue_ff.col == issue.col), "bias read and write-back hit the same entry")
   `FTBC_ASSERT_NEXT(a_wr_marks_valid, clock, reset, wr_en, entry_valid_ff[$past(b_issue_ff.col)], "written bias entry not marked valid")

endmodule

[rtl/core/ftbc_mac_array.sv]
// Six multiply-accumulate lanes, one calibration column per cycle, with rounding and saturation.
module ftbc_mac_array (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ftbc_pkg::diff_ctl_type                 diff_ctl,
   input  logic signed [ftbc_pkg::DIFF_WIDTH-1:0] diff,
   output logic                                   fin_valid,
   output ftbc_pkg::rsp_type                      fin_data
);
   import ftbc_pkg::*;

   localparam logic signed [ACC_WIDTH-1:0] ROUND_HALF = ACC_WIDTH'(1) << (COEF_FRAC - 1);
   localparam logic signed [ACC_WIDTH-1:0] RES_MAX =
      ACC_WIDTH'((longint'(1) << (RESULT_WIDTH - 1)) - 1);
   localparam logic signed [ACC_WIDTH-1:0] RES_MIN = -RES_MAX - ACC_WIDTH'(1);

   logic                          c_valid_ff;
   logic [COL_WIDTH-1:0]          c_col_ff;
   logic signed [DIFF_WIDTH-1:0]  c_diff_ff;
   logic signed [COEF_WIDTH-1:0]  coef_ff [CHANNELS];
   logic                          p_valid_ff;
   logic [COL_WIDTH-1:0]          p_col_ff;
   logic signed [PROD_WIDTH-1:0]  prod_ff [CHANNELS];
   logic signed [PROD_WIDTH-1:0]  prod_in [CHANNELS];
   logic signed [ACC_WIDTH-1:0]   acc_ff  [CHANNELS];
   logic signed [ACC_WIDTH-1:0]   acc_in  [CHANNELS];
   logic                          fin_ff;

   function automatic logic signed [RESULT_WIDTH-1:0] sat_result(
      input logic signed [ACC_WIDTH-1:0] acc);
      logic signed [ACC_WIDTH-1:0] r;
      r = acc >>> COEF_FRAC;
      if (r > RES_MAX) begin
         return RES_MAX[RESULT_WIDTH-1:0];
      end else if (r < RES_MIN) begin
         return RES_MIN[RESULT_WIDTH-1:0];
      end
      return r[RESULT_WIDTH-1:0];
   endfunction

   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         prod_in[i] = PROD_WIDTH'(coef_ff[i]) * PROD_WIDTH'(c_diff_ff);
         if (p_col_ff == FIRST_COL) begin
            acc_in[i] = ACC_WIDTH'(prod_ff[i]) + ROUND_HALF;
         end else begin
            acc_in[i] = acc_ff[i] + ACC_WIDTH'(prod_ff[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      c_col_ff  <= diff_ctl.col;
      c_diff_ff <= diff;
      p_col_ff  <= c_col_ff;
      for (int i = 0; i < CHANNELS; i++) begin
         coef_ff[i] <= COEF_TABLE[i][diff_ctl.col];
         prod_ff[i] <= prod_in[i];
         if (p_valid_ff) begin
            acc_ff[i] <= acc_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         p_valid_ff <= 1'b0;
         fin_ff     <= 1'b0;
      end else begin
         c_valid_ff <= diff_ctl.valid;
         p_valid_ff <= c_valid_ff;
         fin_ff     <= p_valid_ff && (p_col_ff == LAST_COL);
      end
   end

   assign fin_valid         = fin_ff;
   assign fin_data.force_x  = sat_result(acc_ff[0]);
   assign fin_data.force_y  = sat_result(acc_ff[1]);
   assign fin_data.force_z  = sat_result(acc_ff[2]);
   assign fin_data.torque_x = sat_result(acc_ff[3]);
   assign fin_data.torque_y = sat_result(acc_ff[4]);
   assign fin_data.torque_z = sat_result(acc_ff[5]);

endmodule

[rtl/core/ftbc_rsp_queue.sv]
// Result queue with slot reservation, so finished items never meet a full queue.
`include "force_torque_bias_and_calibration_assert.svh"
module ftbc_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              reserve,
   output logic              can_reserve,
   input  logic              push,
   input  ftbc_pkg::rsp_type push_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ftbc_pkg::rsp_type rsp_data
);
   import ftbc_pkg::*;

   rsp_type               slot_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0] wr_ptr_ff;
   logic [QPTR_WIDTH-1:0] rd_ptr_ff;
   logic [QCNT_WIDTH-1:0] count_ff;
   logic [QCNT_WIDTH-1:0] reserved_ff;
   logic                  pop;

   assign pop         = rsp_valid && rsp_ready;
   assign rsp_valid   = (count_ff != '0);
   assign rsp_data    = slot_ff[rd_ptr_ff];
   assign can_reserve = (reserved_ff < QCNT_WIDTH'(QUEUE_DEPTH));

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
         reserved_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_WIDTH'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_WIDTH'(1);
         end
         count_ff    <= count_ff + QCNT_WIDTH'(push) - QCNT_WIDTH'(pop);
         reserved_ff <= reserved_ff + QCNT_WIDTH'(reserve) - QCNT_WIDTH'(pop);
      end
   end

   `FTBC_ASSERT_NEVER(a_push_full, clock, reset, push && (count_ff == QCNT_WIDTH'(QUEUE_DEPTH)), "result pushed into a full queue")
   `FTBC_ASSERT_NEVER(a_unreserved, clock, reset, count_ff > reserved_ff, "queue holds an item without a reserved slot")

endmodule

[bench/tb_force_torque_bias_and_calibration.sv]
// Self-checking bench for the six-axis force/torque bias and calibration block.
module tb_force_torque_bias_and_calibration;
   import ftbc_pkg::*;

   // action code that the block must ignore
   localparam logic [ACTION_WIDTH-1:0] ACTION_UNUSED = 2'd3;

   // bias sums are SAMPLE_WIDTH + 6 bits wide for 64 samples
   localparam int     BIAS_LOG2 = 6;
   localparam longint SUM_MAX   = (64'sd1 <<< (SAMPLE_WIDTH + BIAS_LOG2 - 1)) - 1;
   localparam longint SUM_MIN   = -(64'sd1 <<< (SAMPLE_WIDTH + BIAS_LOG2 - 1));
   // 20 (LSB to Q16.16) * 2^22 (Q10.22) * 1e4 (matrix in 1e-5 over scale in 1e-9)
   localparam longint GAIN_NUM  = 64'sd838860800000;
   localparam longint OUT_MAX   = 64'sd2147483647;
   localparam longint OUT_MIN   = -64'sd2147483648;

   localparam int RANDOM_ITEMS = 660;
   localparam int REPORT_LIMIT = 10;
   localparam int QUIET_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 40;

   localparam rsp_type ZERO_WRENCH = '0;

   // gauge calibration matrix in 1e-5 units, row per output axis
   localparam longint MATRIX_E5 [36] = '{
      -40709, -27318, 34868, -3358156, -32609, 3354162,
      35472, 3822730, -41173, -1949156, 49550, -1915271,
      1872635, -59676, 1927843, -56931, 1869352, -67633,
      -40836, -95908, -3337957, 138537, 3252522, -51156,
      3713715, -102875, -2000474, -27959, -1934135, 142577,
      -15775, -1816831, -133, -1878961, 31895, -1838586
   };
   // per-axis scale in 1e-9 units
   localparam longint SCALE_E9 [CHANNELS] = '{
      64'sd4551197212, 64'sd4551197212, 64'sd1412440514,
      64'sd84884324558, 64'sd84884324558, 64'sd80947203753
   };

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type wrench;
   } stim_row;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // predictor state
   longint  bias_total [CHANNELS];
   longint  gauge_gain [CHANNELS][CHANNELS];
   rsp_type pending_wrench [$];

   string   axis_name [CHANNELS] = '{"force_x", "force_y", "force_z",
                                     "torque_x", "torque_y", "torque_z"};
   int      offset [CHANNELS];
   int      fail_count    = 0;
   int      sent_count    = 0;
   int      quiet_cycles  = 0;
   int      ready_left    = 0;
   bit      sender_steady = 1'b0;

   force_torque_bias_and_calibration dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Fold each axis scale into its matrix row, rounding the magnitude half up.
   function automatic void load_gains();
      longint mag;
      longint q;
      for (int i = 0; i < CHANNELS; i++) begin
         for (int j = 0; j < CHANNELS; j++) begin
            mag = (MATRIX_E5[i*6+j] < 0) ? -MATRIX_E5[i*6+j] : MATRIX_E5[i*6+j];
            q = (mag * GAIN_NUM + SCALE_E9[i] / 2) / SCALE_E9[i];
            gauge_gain[i][j] = (MATRIX_E5[i*6+j] < 0) ? -q : q;
         end
         bias_total[i] = 0;
      end
   endfunction

   function automatic longint channel_of(req_type it, int j);
      case (j)
         0:       return longint'($signed(it.channel_0));
         1:       return longint'($signed(it.channel_1));
         2:       return longint'($signed(it.channel_2));
         3:       return longint'($signed(it.channel_3));
         4:       return longint'($signed(it.channel_4));
         default: return longint'($signed(it.channel_5));
      endcase
   endfunction

   function automatic req_type with_channel(req_type it, int j, logic [15:0] v);
      case (j)
         0:       it.channel_0 = v;
         1:       it.channel_1 = v;
         2:       it.channel_2 = v;
         3:       it.channel_3 = v;
         4:       it.channel_4 = v;
         default: it.channel_5 = v;
      endcase
      return it;
   endfunction

   function automatic logic [31:0] axis_of(rsp_type w, int i);
      case (i)
         0:       return w.force_x;
         1:       return w.force_y;
         2:       return w.force_z;
         3:       return w.torque_x;
         4:       return w.torque_y;
         default: return w.torque_z;
      endcase
   endfunction

   // Advance the bias store by one item; return 1 with the wrench on a convert.
   function automatic bit predict_wrench(req_type it, output rsp_type w);
      longint diff [CHANNELS];
      longint acc;
      longint r;
      longint s;
      logic [31:0] axis [CHANNELS];
      w = '0;
      case (it.action)
         ACTION_CLEAR: begin
            for (int j = 0; j < CHANNELS; j++) bias_total[j] = 0;
            return 1'b0;
         end
         ACTION_ACCUM: begin
            // saturate each sum at the limits of its width
            for (int j = 0; j < CHANNELS; j++) begin
               s = bias_total[j] + channel_of(it, j);
               if (s > SUM_MAX) s = SUM_MAX;
               else if (s < SUM_MIN) s = SUM_MIN;
               bias_total[j] = s;
            end
            return 1'b0;
         end
         ACTION_CONVERT: begin
            // bias is the sum over 64, rounded half up
            for (int j = 0; j < CHANNELS; j++)
               diff[j] = channel_of(it, j) -
                         ((bias_total[j] + (64'sd1 <<< (BIAS_LOG2 - 1))) >>> BIAS_LOG2);
            for (int i = 0; i < CHANNELS; i++) begin
               acc = 0;
               for (int j = 0; j < CHANNELS; j++) acc += gauge_gain[i][j] * diff[j];
               r = (acc + (64'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
               if (r > OUT_MAX) r = OUT_MAX;
               else if (r < OUT_MIN) r = OUT_MIN;
               axis[i] = r[31:0];
            end
            w.force_x  = axis[0];
            w.force_y  = axis[1];
            w.force_z  = axis[2];
            w.torque_x = axis[3];
            w.torque_y = axis[4];
            w.torque_z = axis[5];
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic void check_wrench(rsp_type got);
      rsp_type want;
      if (pending_wrench.size() == 0) begin
         fail_count++;
         if (fail_count <= REPORT_LIMIT) $display("unexpected result item %h", got);
         return;
      end
      want = pending_wrench.pop_front();
      for (int i = 0; i < CHANNELS; i++) begin
         if (axis_of(got, i) !== axis_of(want, i)) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("%s mismatch: expected %0d, got %0d", axis_name[i],
                        $signed(axis_of(want, i)), $signed(axis_of(got, i)));
         end
      end
   endfunction

   // mostly back to back, sometimes a few cycles, rarely a long pause
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [15:0] any_sample();
      case ($urandom_range(0, 9))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type item_of(logic [ACTION_WIDTH-1:0] act, int c0, int c1,
                                       int c2, int c3, int c4, int c5);
      req_type it;
      it.action    = act;
      it.channel_0 = 16'(c0);
      it.channel_1 = 16'(c1);
      it.channel_2 = 16'(c2);
      it.channel_3 = 16'(c3);
      it.channel_4 = 16'(c4);
      it.channel_5 = 16'(c5);
      return it;
   endfunction

   function automatic req_type random_item(logic [ACTION_WIDTH-1:0] act);
      req_type it;
      it.action = act;
      for (int j = 0; j < CHANNELS; j++) it = with_channel(it, j, any_sample());
      return it;
   endfunction

   // each channel scattered around the episode's offset
   function automatic req_type item_near(logic [ACTION_WIDTH-1:0] act, int spread);
      req_type it;
      int v;
      it.action = act;
      for (int j = 0; j < CHANNELS; j++) begin
         v = offset[j] + int'($urandom_range(0, 2 * spread)) - spread;
         it = with_channel(it, j, 16'(v));
      end
      return it;
   endfunction

   // Offer one item, hold it until accepted, then predict what it causes.
   task automatic push_item(input req_type it, input bit typed, input rsp_type typed_wrench);
      int gap;
      rsp_type w;
      gap = sender_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      if (predict_wrench(it, w)) begin
         pending_wrench.push_back(typed ? typed_wrench : w);
      end
      if (it.action != ACTION_UNUSED) sent_count++;
   endtask

   // Drop valid and hold off until every expected result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_wrench.size() != 0) @(posedge clock);
   endtask

   function automatic void add_row(ref stim_row rows [$], input req_type it, input bit typed,
                                   input rsp_type wrench);
      stim_row row;
      row.item   = it;
      row.typed  = typed;
      row.wrench = wrench;
      rows.push_back(row);
   endfunction

   // Result side: check every accepted item, then alternate ready phases of random length.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_wrench(rsp_data);
      if (ready_left > 0) begin
         ready_left--;
      end else if (rsp_ready) begin
         ready_left = pick_gap();
         if (ready_left > 0) begin
            rsp_ready  <= 1'b0;
            ready_left = ready_left - 1;
         end else begin
            ready_left = $urandom_range(0, 8);
         end
      end else begin
         rsp_ready  <= 1'b1;
         // now and then a long stretch with no stalls at all
         ready_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(0, 12);
      end
   end

   // Watchdog: end the run when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("force_torque_bias_and_calibration regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      stim_row directed [$];
      int kind;
      int n;
      int spread;

      load_gains();

      // After reset the bias is zero, so a zero input converts to a zero wrench.
      add_row(directed, item_of(ACTION_CONVERT, 0, 0, 0, 0, 0, 0), 1'b1, ZERO_WRENCH);
      add_row(directed, item_of(ACTION_CONVERT, 32767, 32767, 32767, 32767, 32767, 32767),
              1'b0, ZERO_WRENCH);
      add_row(directed, item_of(ACTION_CONVERT, -32768, -32768, -32768, -32768, -32768,
                                -32768), 1'b0, ZERO_WRENCH);
      add_row(directed, item_of(ACTION_CONVERT, 32767, -32768, 32767, -32768, 32767, -32768),
              1'b0, ZERO_WRENCH);
      // the unused code must leave the bias alone and give nothing back
      add_row(directed, item_of(ACTION_UNUSED, 23130, -23131, 32767, -32768, 1, -1),
              1'b0, ZERO_WRENCH);
      add_row(directed, item_of(ACTION_CONVERT, 0, 0, 0, 0, 0, 0), 1'b1, ZERO_WRENCH);
      // bias rounding: sum 32 gives 1, sum -32 gives 0, sum -33 gives -1
      add_row(directed, item_of(ACTION_ACCUM, 32, 32, 32, 32, 32, 32), 1'b0, ZERO_WRENCH);
      add_row(directed, item_of(ACTION_CONVERT, 0, 0, 0, 0, 0, 0), 1'b0, ZERO_WRENCH);
      add_row(directed, item_of(ACTION_CLEAR, 0, 0, 0, 0, 0, 0), 1'b0, ZERO_WRENCH);
      add_row(directed, item_of(ACTION_ACCUM, -32, -32, -32, -32, -32, -32), 1'b0,
              ZERO_WRENCH);
      add_row(directed, item_of(ACTION_CONVERT, 0, 0, 0, 0, 0, 0), 1'b0, ZERO_WRENCH);
      add_row(directed, item_of(ACTION_ACCUM, -1, -1, -1, -1, -1, -1), 1'b0, ZERO_WRENCH);
      add_row(directed, item_of(ACTION_CONVERT, 32767, 32767, 32767, 32767, 32767, 32767),
              1'b0, ZERO_WRENCH);
      // fewer samples than the full count, full scale, then a negative full-scale input
      add_row(directed, item_of(ACTION_ACCUM, 32767, 32767, 32767, 32767, 32767, 32767),
              1'b0, ZERO_WRENCH);
      add_row(directed, item_of(ACTION_ACCUM, 32767, 32767, 32767, 32767, 32767, 32767),
              1'b0, ZERO_WRENCH);
      add_row(directed, item_of(ACTION_CONVERT, -32768, -32768, -32768, -32768, -32768,
                                -32768), 1'b0, ZERO_WRENCH);
      // clear ignores its payload
      add_row(directed, item_of(ACTION_CLEAR, -1, 32767, -32768, 12345, -12345, 1), 1'b0,
              ZERO_WRENCH);
      add_row(directed, item_of(ACTION_CONVERT, 0, 0, 0, 0, 0, 0), 1'b1, ZERO_WRENCH);
      add_row(directed, item_of(ACTION_ACCUM, 1, -1, 2, -2, 4, -4), 1'b0, ZERO_WRENCH);
      add_row(directed, item_of(ACTION_CONVERT, -32768, 32767, -32768, 32767, -32768, 32767),
              1'b0, ZERO_WRENCH);
      add_row(directed, item_of(ACTION_CLEAR, 0, 0, 0, 0, 0, 0), 1'b0, ZERO_WRENCH);
      add_row(directed, item_of(ACTION_UNUSED, -32768, -32768, -32768, -32768, -32768,
                                -32768), 1'b0, ZERO_WRENCH);
      add_row(directed, item_of(ACTION_CONVERT, 0, 0, 0, 0, 0, 0), 1'b1, ZERO_WRENCH);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[r]) push_item(directed[r].item, directed[r].typed, directed[r].wrench);

      // hold the sender until the directed results are all back
      drain_results();
      sent_count = 0;

      while (sent_count < RANDOM_ITEMS) begin
         sender_steady = ($urandom_range(0, 4) == 0);
         kind = $urandom_range(0, 9);
         if (kind <= 5) begin
            // well-formed calibration: usually a clear, a full bias set, then measurements
            for (int j = 0; j < CHANNELS; j++)
               offset[j] = int'($signed(any_sample())) >>> $urandom_range(0, 4);
            spread = $urandom_range(0, 1) ? $urandom_range(0, 2000) : $urandom_range(0, 40);
            // now and then skip the clear so the sums pile onto the old ones
            if ($urandom_range(0, 7) != 0)
               push_item(random_item(ACTION_CLEAR), 1'b0, ZERO_WRENCH);
            repeat (BIAS_SAMPLES) push_item(item_near(ACTION_ACCUM, spread), 1'b0, ZERO_WRENCH);
            n = $urandom_range(3, 10);
            repeat (n) begin
               if ($urandom_range(0, 1))
                  push_item(item_near(ACTION_CONVERT, 8000), 1'b0, ZERO_WRENCH);
               else
                  push_item(random_item(ACTION_CONVERT), 1'b0, ZERO_WRENCH);
            end
         end else if (kind == 6) begin
            // overfill with full-scale samples so the sums saturate
            for (int j = 0; j < CHANNELS; j++)
               offset[j] = $urandom_range(0, 1) ? 32767 : -32768;
            push_item(random_item(ACTION_CLEAR), 1'b0, ZERO_WRENCH);
            n = $urandom_range(65, 80);
            repeat (n) push_item(item_near(ACTION_ACCUM, 0), 1'b0, ZERO_WRENCH);
            n = $urandom_range(2, 5);
            repeat (n) push_item(random_item(ACTION_CONVERT), 1'b0, ZERO_WRENCH);
         end else if (kind == 7) begin
            // short bias set
            for (int j = 0; j < CHANNELS; j++) offset[j] = int'($signed(any_sample()));
            if ($urandom_range(0, 1)) push_item(random_item(ACTION_CLEAR), 1'b0, ZERO_WRENCH);
            n = $urandom_range(1, 30);
            repeat (n) push_item(item_near(ACTION_ACCUM, 500), 1'b0, ZERO_WRENCH);
            n = $urandom_range(2, 5);
            repeat (n) push_item(random_item(ACTION_CONVERT), 1'b0, ZERO_WRENCH);
         end else begin
            // noise: any action, the unused one included
            n = $urandom_range(10, 30);
            repeat (n) push_item(random_item(2'($urandom_range(0, 3))), 1'b0, ZERO_WRENCH);
         end
         if ($urandom_range(0, 3) == 0) drain_results();
      end

      sender_steady = 1'b0;
      req_valid <= 1'b0;
      while (pending_wrench.size() != 0) @(posedge clock);
      // advance a little further to catch any stray result
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending_wrench.size() == 0) begin
         $display("force_torque_bias_and_calibration regression: pass");
      end else begin
         $display("force_torque_bias_and_calibration regression: fail");
      end
      $finish;
   end

endmodule
